// ===== src/mpts_pkg.sv =====
// package for the multi-policy task scheduler: types, constants, codes
// no dependencies
`timescale 1ns / 1ps
package mpts_pkg;
   localparam int MAX_TASKS_DEF = 8;
   localparam logic [15:0] CLOCK_MAX = 16'hFFFF;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   typedef enum logic [2:0] {
      MODE_FCFS  = 3'd0,
      MODE_SJF   = 3'd1,
      MODE_SRTF  = 3'd2,
      MODE_PRIO  = 3'd3,
      MODE_PPRIO = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_AGE,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]  slot;
      logic [7:0]  arrival;
      logic [7:0]  cpu_len;
      logic [3:0]  prio_level;
      logic        has_io;
      logic [7:0]  io_offset;
      logic [7:0]  io_length;
      logic        req_type;
   } req_type_type;

   typedef struct packed {
      logic [15:0] tick_time;
      logic        idle;
      logic [2:0]  task_res;
      logic        finished;
      logic        io_started;
      logic [15:0] finish_time;
      logic [15:0] turnaround;
      logic [15:0] waiting;
      logic        all_done;
   } rsp_type;

   // key for the selection compare: 16 bits covers ready time
   function automatic logic [15:0] sort_key(input logic [2:0] mode, input logic [7:0] rem,
                                            input logic [3:0] prio, input logic [15:0] rt);
      logic [15:0] k;
      k = rt;
      if (mode == MODE_SJF || mode == MODE_SRTF) k = {8'd0, rem};
      else if (mode == MODE_PRIO || mode == MODE_PPRIO) k = {12'd0, prio};
      return k;
   endfunction
endpackage

// ===== src/mpts_if.sv =====
// valid/ready channel interface carrying a payload struct
// depends on nothing but its type parameter
`timescale 1ns / 1ps
interface mpts_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/mpts_table.sv =====
// per-entry task state registers, one entry updated per cycle
// depends on mpts_pkg
`timescale 1ns / 1ps
module mpts_table import mpts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_en,
   input  req_type_type     load_data,
   input  logic [IW-1:0]    rd_idx,
   output logic [7:0]       rd_arrival,
   output logic [7:0]       rd_burst,
   output logic [3:0]       rd_prio,
   output logic             rd_has_io,
   output logic [7:0]       rd_io_start,
   output logic [7:0]       rd_io_burst,
   output logic [7:0]       rd_remaining,
   output logic [7:0]       rd_executed,
   output logic [7:0]       rd_io_left,
   output logic             rd_io_taken,
   output logic             rd_blocked,
   output logic [15:0]      rd_ready_time,
   output logic             rd_complete,
   input  logic             wr_en,
   input  logic [IW-1:0]    wr_idx,
   input  logic [7:0]       wr_remaining,
   input  logic [7:0]       wr_executed,
   input  logic [7:0]       wr_io_left,
   input  logic             wr_io_taken,
   input  logic             wr_blocked,
   input  logic [15:0]      wr_ready_time,
   input  logic             wr_complete
);
   logic [7:0]  arr_ff [MAX_TASKS];
   logic [7:0]  bur_ff [MAX_TASKS];
   logic [3:0]  pri_ff [MAX_TASKS];
   logic        hio_ff [MAX_TASKS];
   logic [7:0]  ios_ff [MAX_TASKS];
   logic [7:0]  iob_ff [MAX_TASKS];
   logic [7:0]  rem_ff [MAX_TASKS];
   logic [7:0]  exe_ff [MAX_TASKS];
   logic [7:0]  iol_ff [MAX_TASKS];
   logic        iot_ff [MAX_TASKS];
   logic        blk_ff [MAX_TASKS];
   logic [15:0] rdt_ff [MAX_TASKS];
   logic        cmp_ff [MAX_TASKS];
   logic [IW-1:0] lslot;

   assign lslot = IW'(load_data.slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            rem_ff[i] <= '0;
            blk_ff[i] <= 1'b0;
            cmp_ff[i] <= 1'b0;
         end
      end else if (load_en) begin
         arr_ff[lslot] <= load_data.arrival;
         bur_ff[lslot] <= load_data.cpu_len;
         pri_ff[lslot] <= load_data.prio_level;
         hio_ff[lslot] <= load_data.has_io;
         ios_ff[lslot] <= load_data.io_offset;
         iob_ff[lslot] <= load_data.io_length;
         rem_ff[lslot] <= load_data.cpu_len;
         exe_ff[lslot] <= '0;
         iol_ff[lslot] <= '0;
         iot_ff[lslot] <= 1'b0;
         blk_ff[lslot] <= 1'b0;
         rdt_ff[lslot] <= {8'd0, load_data.arrival};
         cmp_ff[lslot] <= 1'b0;
      end else if (wr_en) begin
         rem_ff[wr_idx] <= wr_remaining;
         exe_ff[wr_idx] <= wr_executed;
         iol_ff[wr_idx] <= wr_io_left;
         iot_ff[wr_idx] <= wr_io_taken;
         blk_ff[wr_idx] <= wr_blocked;
         rdt_ff[wr_idx] <= wr_ready_time;
         cmp_ff[wr_idx] <= wr_complete;
      end
   end

   assign rd_arrival    = arr_ff[rd_idx];
   assign rd_burst      = bur_ff[rd_idx];
   assign rd_prio       = pri_ff[rd_idx];
   assign rd_has_io     = hio_ff[rd_idx];
   assign rd_io_start   = ios_ff[rd_idx];
   assign rd_io_burst   = iob_ff[rd_idx];
   assign rd_remaining  = rem_ff[rd_idx];
   assign rd_executed   = exe_ff[rd_idx];
   assign rd_io_left    = iol_ff[rd_idx];
   assign rd_io_taken   = iot_ff[rd_idx];
   assign rd_blocked    = blk_ff[rd_idx];
   assign rd_ready_time = rdt_ff[rd_idx];
   assign rd_complete   = cmp_ff[rd_idx];
endmodule

// ===== src/multi_policy_task_scheduler.sv =====
// multi-policy task scheduler (FCFS, SJF, SRTF, priority) top level
// depends on mpts_pkg, mpts_if, mpts_table
`timescale 1ns / 1ps
// A load writes its entry into the task table as it is accepted. A tick walks
// the N entries in use through one shared compare unit: it selects (one entry
// per cycle plus the end check), runs the chosen task, ages I/O waits and
// counts completions, steps the clock and posts the result. In a
// non-preemptive mode a kept task that is still ready skips the scan; a kept
// task that is no longer ready is checked alone before the full scan. A result
// waiting in the output register does not block the input; the next tick
// stalls before posting until it has been handed off.
module multi_policy_task_scheduler import mpts_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mpts_if.sink        req,
   mpts_if.source      rsp,
   input  logic        csr_we,
   input  logic        csr_idx,
   input  logic [3:0]  csr_wdata
);
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   state_type state_ff, state_in;
   logic [2:0]    mode_ff;
   logic [3:0]    count_ff;
   logic [15:0]   clk_ff, clk_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic          curv_ff, curv_in;
   logic [IW:0]   idx_ff, idx_in;
   logic          have_ff, have_in;
   logic [IW-1:0] sel_ff, sel_in;
   logic [15:0]   best_ff, best_in;
   logic [15:0]   t0_ff, t0_in;
   logic          fin_ff, fin_in, io_ff, io_in;
   logic [CW-1:0] fcnt_ff, fcnt_in;
   rsp_type       work_ff, work_in;
   rsp_type       out_ff, out_in;
   logic          ovalid_ff, ovalid_in;

   logic [CW-1:0] n_used;
   logic [2:0]    mode_eff;
   logic          preempt;
   logic [IW-1:0] rd_idx;
   logic          load_en;
   logic [7:0]  r_arr, r_bur, r_ios, r_iob, r_rem, r_exe, r_iol;
   logic [3:0]  r_pri;
   logic        r_hio, r_iot, r_blk, r_cmp;
   logic [15:0] r_rdt;
   logic        wr_en;
   logic [7:0]  w_rem, w_exe, w_iol;
   logic        w_iot, w_blk, w_cmp;
   logic [15:0] w_rdt;
   logic        rdy;
   logic [15:0] key;
   logic [15:0] clk_next;
   logic [15:0] turn;
   logic [16:0] sub;

   assign n_used   = (int'(count_ff) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(count_ff);
   assign mode_eff = (mode_ff > MODE_PPRIO) ? MODE_FCFS : mode_ff;
   assign preempt  = (mode_eff == MODE_SRTF) || (mode_eff == MODE_PPRIO);
   assign clk_next = (clk_ff == CLOCK_MAX) ? clk_ff : clk_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FCFS;
         count_ff <= 4'd1;
      end else if (csr_we) begin
         if (csr_idx == CSR_MODE) mode_ff <= csr_wdata[2:0];
         else count_ff <= csr_wdata;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign load_en = req.valid && req.ready && (req.data.req_type == REQ_LOAD)
                    && (int'(req.data.slot) < MAX_TASKS);

   // read address: the selected task while executing, else the walk index
   assign rd_idx = (state_ff == ST_EXEC) ? sel_ff : idx_ff[IW-1:0];

   mpts_table #(.MAX_TASKS(MAX_TASKS), .IW(IW)) u_table (
      .clock, .reset, .load_en, .load_data(req.data), .rd_idx,
      .rd_arrival(r_arr), .rd_burst(r_bur), .rd_prio(r_pri), .rd_has_io(r_hio),
      .rd_io_start(r_ios), .rd_io_burst(r_iob), .rd_remaining(r_rem),
      .rd_executed(r_exe), .rd_io_left(r_iol), .rd_io_taken(r_iot),
      .rd_blocked(r_blk), .rd_ready_time(r_rdt), .rd_complete(r_cmp),
      .wr_en, .wr_idx(rd_idx), .wr_remaining(w_rem), .wr_executed(w_exe),
      .wr_io_left(w_iol), .wr_io_taken(w_iot), .wr_blocked(w_blk),
      .wr_ready_time(w_rdt), .wr_complete(w_cmp)
   );

   assign rdy = !r_cmp && !r_blk && ({8'd0, r_arr} <= clk_ff) && (r_rem != 8'd0);
   assign key = sort_key(mode_eff, r_rem, r_pri, r_rdt);
   // run-unit arithmetic, on the post-tick clock
   assign turn = clk_next - {8'd0, r_arr};
   assign sub  = {9'd0, r_bur} + (r_hio ? {9'd0, r_iob} : 17'd0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid && req.ready && req.data.req_type == REQ_TICK)
                     state_in = ST_SCAN;
         ST_SCAN: if (!curv_ff && idx_ff >= (IW+1)'(n_used)) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_AGE;
         ST_AGE:  if (idx_ff >= (IW+1)'(n_used)) state_in = ST_DONE;
         ST_DONE: state_in = ST_OUT;
         ST_OUT:  if (!ovalid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clk_in = clk_ff; cur_in = cur_ff; curv_in = curv_ff; idx_in = idx_ff;
      have_in = have_ff; sel_in = sel_ff; best_in = best_ff; t0_in = t0_ff;
      fin_in = fin_ff; io_in = io_ff; fcnt_in = fcnt_ff; out_in = out_ff;
      work_in = work_ff;
      ovalid_in = ovalid_ff;
      wr_en = 1'b0;
      w_rem = r_rem; w_exe = r_exe; w_iol = r_iol; w_iot = r_iot;
      w_blk = r_blk; w_rdt = r_rdt; w_cmp = r_cmp;
      if (rsp.valid && rsp.ready) ovalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               if (req.data.req_type == REQ_LOAD) begin
                  if (load_en) begin
                     clk_in = '0;
                     curv_in = 1'b0;
                  end
               end else begin
                  t0_in = clk_ff; fin_in = 1'b0; io_in = 1'b0; fcnt_in = '0;
                  work_in = '0;
                  // kept task first in non-preemptive modes
                  idx_in = (!preempt && curv_ff) ? {1'b0, cur_ff} : '0;
                  if (preempt) curv_in = 1'b0;
                  have_in = 1'b0;
                  best_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (curv_ff) begin
               // check the kept task alone, then fall back to a full scan
               curv_in = 1'b0;
               if (idx_ff < (IW+1)'(n_used) && rdy) begin
                  have_in = 1'b1; sel_in = idx_ff[IW-1:0];
                  idx_in = (IW+1)'(n_used);
               end else idx_in = '0;
            end else if (idx_ff < (IW+1)'(n_used)) begin
               if (rdy && (!have_ff || key < best_ff)) begin
                  have_in = 1'b1; best_in = key; sel_in = idx_ff[IW-1:0];
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EXEC: begin
            idx_in = '0;
            if (have_ff) begin
               wr_en = 1'b1;
               w_rem = r_rem - 8'd1;
               w_exe = (r_exe == 8'hFF) ? r_exe : r_exe + 8'd1;
               if (w_rem == 8'd0) begin
                  w_cmp = 1'b1; fin_in = 1'b1;
                  work_in.finish_time = clk_next;
                  work_in.turnaround = turn;
                  work_in.waiting = ({1'b0, turn} > sub) ? 16'({1'b0, turn} - sub) : 16'd0;
               end else if (r_hio && !r_iot && w_exe == r_ios) begin
                  // aging of this wait starts on the next tick
                  w_blk = 1'b1; w_iot = 1'b1; io_in = 1'b1;
                  w_iol = r_iob;
               end else if (!preempt) begin
                  cur_in = sel_ff; curv_in = 1'b1;
               end
            end
         end
         ST_AGE: begin
            if (idx_ff < (IW+1)'(n_used)) begin
               if (r_blk && !(io_ff && idx_ff[IW-1:0] == sel_ff)) begin
                  wr_en = 1'b1;
                  if (r_iol <= 8'd1) begin
                     w_iol = 8'd0; w_blk = 1'b0; w_rdt = clk_next;
                  end else w_iol = r_iol - 8'd1;
               end
               if (r_cmp) fcnt_in = fcnt_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            clk_in = clk_next;
         end
         ST_OUT: begin
            // post once the output register is free or being emptied
            if (!ovalid_ff || rsp.ready) begin
               out_in = work_ff;
               out_in.tick_time = t0_ff;
               out_in.idle = !have_ff;
               out_in.task_res = have_ff ? 3'(sel_ff) : 3'd0;
               out_in.finished = fin_ff;
               out_in.io_started = io_ff;
               out_in.all_done = (fcnt_ff == n_used);
               ovalid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; clk_ff <= '0; curv_ff <= 1'b0; ovalid_ff <= 1'b0;
         idx_ff <= '0; have_ff <= 1'b0; fin_ff <= 1'b0; io_ff <= 1'b0; fcnt_ff <= '0;
      end else begin
         state_ff <= state_in; clk_ff <= clk_in; curv_ff <= curv_in;
         ovalid_ff <= ovalid_in; idx_ff <= idx_in; have_ff <= have_in;
         fin_ff <= fin_in; io_ff <= io_in; fcnt_ff <= fcnt_in;
      end
      cur_ff <= cur_in; sel_ff <= sel_in; best_ff <= best_in; t0_ff <= t0_in;
      out_ff <= out_in; work_ff <= work_in;
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;

   a_res_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.idle |-> !rsp.data.finished && !rsp.data.io_started)
      else $error("idle result reports activity");
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.data.finished && rsp.data.io_started))
      else $error("finish and io start together");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("ready while working");
   a_post: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp.valid)
      else $error("result lost");
endmodule

// ===== tb/mpts_checker.sv =====
// transaction checker for the multi-policy task scheduler: tracks csr writes,
// predicts one response per tick and compares it with what the block returns
// depends on mpts_pkg
`timescale 1ns / 1ps
module mpts_checker import mpts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_type_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_type      rsp_data,
   input  logic         csr_we,
   input  logic         csr_idx,
   input  logic [3:0]   csr_wdata,
   output int           fail_count,
   output int           pending
);
   localparam int SLOTS = 8;

   logic [7:0]  t_arrival [SLOTS];
   logic [7:0]  t_burst [SLOTS];
   logic [3:0]  t_prio [SLOTS];
   logic        t_has_io [SLOTS];
   logic [7:0]  t_io_start [SLOTS];
   logic [7:0]  t_io_burst [SLOTS];
   logic [7:0]  t_left [SLOTS];
   logic [7:0]  t_ran [SLOTS];
   logic [7:0]  t_io_wait [SLOTS];
   logic        t_io_done [SLOTS];
   logic        t_blocked [SLOTS];
   logic [15:0] t_ready_at [SLOTS];
   logic        t_done [SLOTS];
   logic [15:0] now;
   logic [2:0]  kept_task;
   logic        kept_valid;
   logic [2:0]  cur_mode;
   logic [3:0]  cur_count;

   rsp_type     sched_results [$];
   int          mismatches;

   function automatic int in_use();
      return (cur_count > SLOTS) ? SLOTS : int'(cur_count);
   endfunction

   function automatic bit runnable(int i);
      return !t_done[i] && !t_blocked[i] && ({8'd0, t_arrival[i]} <= now) && t_left[i] != 0;
   endfunction

   function automatic logic [15:0] rank(int i, logic [2:0] m);
      if (m == MODE_SJF || m == MODE_SRTF) return {8'd0, t_left[i]};
      if (m == MODE_PRIO || m == MODE_PPRIO) return {12'd0, t_prio[i]};
      return t_ready_at[i];
   endfunction

   task automatic clear_model();
      for (int i = 0; i < SLOTS; i++) begin
         t_arrival[i] = 0; t_burst[i] = 0; t_prio[i] = 0; t_has_io[i] = 0;
         t_io_start[i] = 0; t_io_burst[i] = 0; t_left[i] = 0; t_ran[i] = 0;
         t_io_wait[i] = 0; t_io_done[i] = 0; t_blocked[i] = 0;
         t_ready_at[i] = 0; t_done[i] = 0;
      end
      now = 0;
      kept_task = 0;
      kept_valid = 0;
      cur_mode = MODE_FCFS;
      cur_count = 1;
   endtask

   task automatic load_entry(req_type_type d);
      int s;
      s = int'(d.slot);
      t_arrival[s] = d.arrival;
      t_burst[s] = d.cpu_len;
      t_prio[s] = d.prio_level;
      t_has_io[s] = d.has_io;
      t_io_start[s] = d.io_offset;
      t_io_burst[s] = d.io_length;
      t_left[s] = d.cpu_len;
      t_ran[s] = 0;
      t_io_wait[s] = 0;
      t_io_done[s] = 0;
      t_blocked[s] = 0;
      t_ready_at[s] = {8'd0, d.arrival};
      t_done[s] = 0;
      now = 0;
      kept_valid = 0;
   endtask

   task automatic run_tick(output rsp_type r);
      logic [2:0]  m;
      bit          preempt, have;
      int          n, sel, done_cnt;
      logic [15:0] best, k, sub;
      m = (cur_mode > MODE_PPRIO) ? MODE_FCFS : cur_mode;
      preempt = (m == MODE_SRTF || m == MODE_PPRIO);
      n = in_use();
      r = '0;
      r.tick_time = now;
      have = 0;
      sel = 0;
      best = 0;
      if (!preempt && kept_valid && int'(kept_task) < n && runnable(kept_task)) begin
         sel = kept_task;
         have = 1;
      end else begin
         for (int i = 0; i < n; i++) begin
            if (runnable(i)) begin
               k = rank(i, m);
               if (!have || k < best) begin
                  have = 1;
                  best = k;
                  sel = i;
               end
            end
         end
      end
      kept_valid = 0;
      if (have) begin
         t_left[sel]--;
         if (t_ran[sel] != 8'hFF) t_ran[sel]++;
      end
      if (now != CLOCK_MAX) now++;
      // waits age before this tick's own i/o start is recorded
      for (int i = 0; i < n; i++) begin
         if (t_blocked[i]) begin
            if (t_io_wait[i] <= 1) begin
               t_io_wait[i] = 0;
               t_blocked[i] = 0;
               t_ready_at[i] = now;
            end else begin
               t_io_wait[i]--;
            end
         end
      end
      if (have) begin
         if (t_left[sel] == 0) begin
            t_done[sel] = 1;
            r.finished = 1;
            r.finish_time = now;
            r.turnaround = now - {8'd0, t_arrival[sel]};
            sub = {8'd0, t_burst[sel]} + (t_has_io[sel] ? {8'd0, t_io_burst[sel]} : 16'd0);
            r.waiting = (r.turnaround > sub) ? r.turnaround - sub : 16'd0;
         end else if (t_has_io[sel] && !t_io_done[sel] && t_ran[sel] == t_io_start[sel]) begin
            t_blocked[sel] = 1;
            t_io_done[sel] = 1;
            t_io_wait[sel] = t_io_burst[sel];
            r.io_started = 1;
         end else if (!preempt) begin
            kept_task = sel[2:0];
            kept_valid = 1;
         end
      end
      done_cnt = 0;
      for (int i = 0; i < n; i++) if (t_done[i]) done_cnt++;
      r.idle = !have;
      r.task_res = have ? sel[2:0] : 3'd0;
      r.all_done = (done_cnt == n);
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got, inout bit bad);
      if (got !== want) begin
         bad = 1;
         if (mismatches < 10)
            $display("mismatch %s: expected %0d got %0d at %0t", name, want, got, $realtime);
      end
   endtask

   task automatic compare_result(rsp_type want, rsp_type got);
      bit bad;
      bad = 0;
      check_field("tick_time", want.tick_time, got.tick_time, bad);
      check_field("idle", 16'(want.idle), 16'(got.idle), bad);
      check_field("task_res", 16'(want.task_res), 16'(got.task_res), bad);
      check_field("finished", 16'(want.finished), 16'(got.finished), bad);
      check_field("io_started", 16'(want.io_started), 16'(got.io_started), bad);
      check_field("finish_time", want.finish_time, got.finish_time, bad);
      check_field("turnaround", want.turnaround, got.turnaround, bad);
      check_field("waiting", want.waiting, got.waiting, bad);
      check_field("all_done", 16'(want.all_done), 16'(got.all_done), bad);
      if (bad) begin
         mismatches++;
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      mismatches = 0;
      clear_model();
   end

   always @(posedge clock) begin
      rsp_type r;
      if (reset) begin
         clear_model();
         sched_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_idx == CSR_MODE) cur_mode = csr_wdata[2:0];
            else cur_count = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (sched_results.size() == 0) begin
               fail_count++;
               if (mismatches < 10)
                  $display("unexpected response at %0t", $realtime);
               mismatches++;
            end else begin
               compare_result(sched_results.pop_front(), rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.req_type == REQ_LOAD) begin
               load_entry(req_data);
            end else begin
               run_tick(r);
               sched_results.push_back(r);
            end
         end
      end
      pending = sched_results.size();
   end
endmodule

// ===== tb/tb.sv =====
// testbench top for the multi-policy task scheduler: clock, reset, stimulus
// and verdict; depends on mpts_pkg, mpts_if, the block and mpts_checker
`timescale 1ns / 1ps
module tb;
   import mpts_pkg::*;

   localparam int CYCLE_LIMIT = 900000;
   localparam int RW = $bits(req_type_type);

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_idx;
   logic [3:0] csr_wdata;
   int         fails;
   int         pending;
   int         cycles;
   int         items;
   bit         quiet;
   bit         hold_req;

   mpts_if #(.payload_type(req_type_type)) req_ch ();
   mpts_if #(.payload_type(rsp_type)) rsp_ch ();

   multi_policy_task_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   mpts_checker chk (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_data  (req_ch.data),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_ch.data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .fail_count(fails),
      .pending   (pending)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ch.ready <= 0;
            repeat (400) @(negedge clock);
            hold_req = 0;
         end else if (quiet || reset || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1;
         end else begin
            rsp_ch.ready <= 0;
            repeat (gap_len() - 1) @(negedge clock);
         end
      end
   end

   // called just after a falling edge, returns just after one
   task automatic send(req_type_type d);
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_ch.valid <= 0;
         repeat (gap_len()) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.data <= d;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items++;
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      // loads make no response, so give the block time to finish one
      repeat (30) @(negedge clock);
   endtask

   task automatic write_cfg(logic [3:0] mode_val, logic [3:0] count_val);
      drain();
      csr_we <= 1;
      csr_idx <= CSR_MODE;
      csr_wdata <= mode_val;
      @(negedge clock);
      csr_idx <= CSR_COUNT;
      csr_wdata <= count_val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic req_type_type tick_item();
      req_type_type d;
      d = RW'({$urandom, $urandom});
      d.req_type = REQ_TICK;
      return d;
   endfunction

   function automatic req_type_type task_item(int s);
      req_type_type d;
      d = RW'({$urandom, $urandom});
      d.req_type = REQ_LOAD;
      d.slot = s[2:0];
      d.arrival = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 12));
      d.cpu_len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(1, 6));
      d.prio_level = 4'($urandom_range(0, 15));
      d.has_io = 1'($urandom_range(0, 1));
      d.io_offset = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 6));
      d.io_length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 4));
      return d;
   endfunction

   function automatic req_type_type fixed_task(int s, logic [7:0] arr, logic [7:0] burst,
                                               logic [3:0] pr, logic io,
                                               logic [7:0] io_at, logic [7:0] io_len);
      req_type_type d;
      d = '0;
      d.req_type = REQ_LOAD;
      d.slot = s[2:0];
      d.arrival = arr;
      d.cpu_len = burst;
      d.prio_level = pr;
      d.has_io = io;
      d.io_offset = io_at;
      d.io_length = io_len;
      return d;
   endfunction

   initial begin
      logic [3:0] m, c;
      int p, n_ticks;
      reset = 1;
      csr_we = 0;
      csr_idx = CSR_MODE;
      csr_wdata = 0;
      req_ch.valid = 0;
      req_ch.data = '0;
      items = 0;
      quiet = 0;
      hold_req = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: every entry loaded once so no tick reads an empty slot
      write_cfg(4'(MODE_FCFS), 4'd8);
      send(fixed_task(0, 8'd0, 8'd1, 4'd0, 1'b0, 8'd0, 8'd0));
      send(fixed_task(1, 8'd255, 8'd255, 4'd15, 1'b1, 8'd255, 8'd255));
      send(fixed_task(2, 8'd0, 8'd3, 4'd2, 1'b1, 8'd1, 8'd0));    // zero-length i/o
      send(fixed_task(3, 8'd1, 8'd0, 4'd1, 1'b0, 8'd0, 8'd0));    // zero burst
      send(fixed_task(4, 8'd2, 8'd5, 4'd4, 1'b1, 8'd2, 8'd3));
      for (int s = 5; s < 8; s++) send(task_item(s));
      repeat (10) send(tick_item());
      for (int k = 1; k <= 7; k++) begin
         write_cfg(4'(k), 4'd8);
         repeat (2) send(tick_item());
      end

      p = 0;
      while (items < 1650) begin
         m = (p < 8) ? 4'(p) : (($urandom_range(0, 5) == 0) ? 4'($urandom_range(5, 7))
                                                            : 4'($urandom_range(0, 4)));
         case (p % 4)
            0: c = 4'd1;
            1: c = 4'd8;
            default: c = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 8));
         endcase
         if (p == 2) c = 4'd0;
         if (p == 3) c = 4'd15;
         quiet = ($urandom_range(0, 4) == 0);
         write_cfg(m, c);
         // some phases keep the table and clock so a kept task can go stale
         if ($urandom_range(0, 4) != 0)
            for (int s = 0; s < 8; s++)
               if (s < int'(c) || $urandom_range(0, 3) == 0) send(task_item(s));
         if (p == 5) hold_req = 1;
         n_ticks = $urandom_range(10, 60);
         repeat (n_ticks) send(tick_item());
         p++;
      end
      quiet = 0;

      req_ch.valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fails == 0 && pending == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule
